// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define SHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/shc_pkg.sv -----
package shc_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BUTTON = 2'd1,
    OP_SAFETY = 2'd2,
    OP_TIMER  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LVL_OFF  = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_MED  = 2'd2,
    LVL_HIGH = 2'd3
  } level_t;

  localparam int unsigned CfgAddrW = 5;

  localparam logic [2:0] REG_MAX_TEMP      = 3'd0;
  localparam logic [2:0] REG_MIN_TEMP      = 3'd1;
  localparam logic [2:0] REG_SHUTDOWN_TEMP = 3'd2;
  localparam logic [2:0] REG_HYSTERESIS    = 3'd3;
  localparam logic [2:0] REG_HIGH_MARGIN   = 3'd4;
  localparam logic [2:0] REG_LOCKOUT_MS    = 3'd5;
  localparam logic [2:0] REG_PWM_PERIOD    = 3'd6;

  localparam logic [6:0]  MAX_TEMP_RST      = 7'd45;
  localparam logic [6:0]  MIN_TEMP_RST      = 7'd15;
  localparam logic [6:0]  SHUTDOWN_TEMP_RST = 7'd50;
  localparam logic [3:0]  HYSTERESIS_RST    = 4'd2;
  localparam logic [4:0]  HIGH_MARGIN_RST   = 5'd5;
  localparam logic [15:0] LOCKOUT_MS_RST    = 16'd200;
  localparam logic [15:0] PWM_PERIOD_RST    = 16'd6250;

  localparam logic [5:0] TARGET_25 = 6'd25;
  localparam logic [5:0] TARGET_30 = 6'd30;
  localparam logic [5:0] TARGET_35 = 6'd35;

  // sensor transfer: 1475*4096 - 2475*code, 20480 counts per degree
  localparam logic signed [25:0] TEMP_OFFSET = 26'sd6041600;
  localparam logic [11:0]        TEMP_SLOPE  = 12'd2475;

  // whole degrees to 20480 counts per degree: deg*5*4096
  function automatic logic signed [25:0] deg_scale(input logic [6:0] deg);
    logic [25:0] d;
    d = {19'd0, deg};
    return $signed((d << 14) + (d << 12));
  endfunction

  function automatic logic [5:0] target_for(input level_t lvl);
    logic [5:0] t;
    case (lvl)
      LVL_OFF:  t = TARGET_25;
      LVL_LOW:  t = TARGET_30;
      LVL_MED:  t = TARGET_35;
      LVL_HIGH: t = TARGET_25;
      default:  t = TARGET_25;
    endcase
    return t;
  endfunction

endpackage

// ----- design/seat_heater_controller.sv -----
// Seat heater controller. One event item per clock is accepted on the in_ channel and
// gives exactly one result item on the out_ channel: the input register is loaded
// first, then the controller state and the result register are updated together
// in one pass of compare and small multiply logic, so the sustained rate is
// one item per cycle whenever out_stall is low. Results show the state after the event:
// level, PWM pulse width (a quarter step of pwm_period), power, lamps, override and
// target. Registers sit on the APB port at byte addresses 0x00 (max_temp), 0x04
// (min_temp), 0x08 (shutdown_temp), 0x0C (hysteresis), 0x10 (high_margin), 0x14
// (lockout_ms) and 0x18 (pwm_period); write them only while no item is in flight.
`include "assert_macros.svh"

module seat_heater_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic [11:0]                  in_adc_code,
  input  logic                         in_power_pin,
  input  logic                         in_level_pin,
  input  logic [31:0]                  in_now_ms,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_heat_level,
  output logic [15:0]                  out_pulse_width,
  output logic                         out_pwm_written,
  output logic                         out_power_state,
  output logic                         out_heating_lamp,
  output logic                         out_fault_lamp,
  output logic                         out_override_state,
  output logic [5:0]                   out_target_degrees,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [shc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // configuration registers
  logic [6:0]  max_temp_r, min_temp_r, shutdown_temp_r;
  logic [3:0]  hysteresis_r;
  logic [4:0]  high_margin_r;
  logic [15:0] lockout_ms_r, pwm_period_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_temp_r      <= shc_pkg::MAX_TEMP_RST;
      min_temp_r      <= shc_pkg::MIN_TEMP_RST;
      shutdown_temp_r <= shc_pkg::SHUTDOWN_TEMP_RST;
      hysteresis_r    <= shc_pkg::HYSTERESIS_RST;
      high_margin_r   <= shc_pkg::HIGH_MARGIN_RST;
      lockout_ms_r    <= shc_pkg::LOCKOUT_MS_RST;
      pwm_period_r    <= shc_pkg::PWM_PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        shc_pkg::REG_MAX_TEMP:      max_temp_r      <= pwdata[6:0];
        shc_pkg::REG_MIN_TEMP:      min_temp_r      <= pwdata[6:0];
        shc_pkg::REG_SHUTDOWN_TEMP: shutdown_temp_r <= pwdata[6:0];
        shc_pkg::REG_HYSTERESIS:    hysteresis_r    <= pwdata[3:0];
        shc_pkg::REG_HIGH_MARGIN:   high_margin_r   <= pwdata[4:0];
        shc_pkg::REG_LOCKOUT_MS:    lockout_ms_r    <= pwdata[15:0];
        shc_pkg::REG_PWM_PERIOD:    pwm_period_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      shc_pkg::REG_MAX_TEMP:      prdata = {25'd0, max_temp_r};
      shc_pkg::REG_MIN_TEMP:      prdata = {25'd0, min_temp_r};
      shc_pkg::REG_SHUTDOWN_TEMP: prdata = {25'd0, shutdown_temp_r};
      shc_pkg::REG_HYSTERESIS:    prdata = {28'd0, hysteresis_r};
      shc_pkg::REG_HIGH_MARGIN:   prdata = {27'd0, high_margin_r};
      shc_pkg::REG_LOCKOUT_MS:    prdata = {16'd0, lockout_ms_r};
      shc_pkg::REG_PWM_PERIOD:    prdata = {16'd0, pwm_period_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // input register and handshake
  logic            s1_valid_r;
  shc_pkg::op_t    s1_op_r;
  logic [11:0]     s1_code_r;
  logic            s1_ppin_r, s1_lpin_r;
  logic [31:0]     s1_now_r;
  logic            out_valid_r;
  logic            s1_adv, in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= shc_pkg::op_t'(in_op);
      s1_code_r <= in_adc_code;
      s1_ppin_r <= in_power_pin;
      s1_lpin_r <= in_level_pin;
      s1_now_r  <= in_now_ms;
    end
  end

  // controller state
  logic                  power_r, power_nxt;
  shc_pkg::level_t       level_r, level_nxt;
  logic [5:0]            target_r, target_nxt;
  logic                  override_r, override_nxt;
  logic                  fault_r, fault_nxt;
  logic signed [23:0]    temp_r, temp_nxt;
  logic                  ppin_prev_r, ppin_prev_nxt;
  logic                  lpin_prev_r, lpin_prev_nxt;
  logic [31:0]           ppress_r, ppress_nxt;
  logic [31:0]           lpress_r, lpress_nxt;
  logic [15:0]           pulse_r, pulse_nxt;
  logic                  wrote_r, wrote_nxt;

  logic [23:0]           slope_prod;
  logic signed [25:0]    temp_new, temp_ext, gap;
  logic signed [25:0]    th_high, th_med;
  logic [5:0]            hm_sum;
  shc_pkg::level_t       lvl_calc;
  logic [17:0]           pw_prod;
  logic [31:0]           pdiff, ldiff;
  logic                  ppress_ok, lpress_ok, found;

  always_comb begin
    slope_prod = 24'(s1_code_r) * 24'(shc_pkg::TEMP_SLOPE);
    temp_new   = shc_pkg::TEMP_OFFSET - $signed({2'b00, slope_prod});
    temp_ext   = 26'(temp_r);
    gap        = shc_pkg::deg_scale({1'b0, target_r}) - temp_new;
    hm_sum     = 6'(hysteresis_r) + 6'(high_margin_r);
    th_high    = shc_pkg::deg_scale({1'b0, hm_sum});
    th_med     = shc_pkg::deg_scale({3'd0, hysteresis_r});

    if (!power_r || override_r) begin
      lvl_calc = shc_pkg::LVL_OFF;
    end else if (gap > th_high) begin
      lvl_calc = shc_pkg::LVL_HIGH;
    end else if (gap > th_med) begin
      lvl_calc = shc_pkg::LVL_MED;
    end else if (gap > 26'sd0) begin
      lvl_calc = shc_pkg::LVL_LOW;
    end else begin
      lvl_calc = shc_pkg::LVL_OFF;
    end
    // quarter steps of the period: 0, 1/4, 1/2, 3/4
    pw_prod = 18'(pwm_period_r) * 18'(lvl_calc);

    pdiff     = s1_now_r - ppress_r;
    ldiff     = s1_now_r - lpress_r;
    ppress_ok = !s1_ppin_r && ppin_prev_r && (pdiff > {16'd0, lockout_ms_r});

    power_nxt     = power_r;
    level_nxt     = level_r;
    target_nxt    = target_r;
    override_nxt  = override_r;
    fault_nxt     = fault_r;
    temp_nxt      = temp_r;
    ppin_prev_nxt = ppin_prev_r;
    lpin_prev_nxt = lpin_prev_r;
    ppress_nxt    = ppress_r;
    lpress_nxt    = lpress_r;
    pulse_nxt     = pulse_r;
    wrote_nxt     = 1'b0;
    lpress_ok     = 1'b0;
    found         = 1'b0;

    case (s1_op_r)
      shc_pkg::OP_SAMPLE: begin
        temp_nxt  = temp_new[23:0];
        level_nxt = lvl_calc;
        pulse_nxt = pw_prod[17:2];
        wrote_nxt = 1'b1;
      end
      shc_pkg::OP_BUTTON: begin
        if (ppress_ok) begin
          power_nxt  = !power_r;
          ppress_nxt = s1_now_r;
          if (power_r) begin
            level_nxt = shc_pkg::LVL_OFF;
          end
        end
        ppin_prev_nxt = s1_ppin_r;
        // level press sees the power value after the power press
        lpress_ok = !s1_lpin_r && lpin_prev_r && power_nxt &&
                    (ldiff > {16'd0, lockout_ms_r});
        if (lpress_ok) begin
          target_nxt = shc_pkg::target_for(level_nxt);
          lpress_nxt = s1_now_r;
        end
        lpin_prev_nxt = s1_lpin_r;
      end
      shc_pkg::OP_SAFETY: begin
        if (temp_ext > shc_pkg::deg_scale(max_temp_r)) begin
          found        = 1'b1;
          override_nxt = 1'b1;
        end else if (temp_ext < shc_pkg::deg_scale(min_temp_r) &&
                     level_r != shc_pkg::LVL_OFF) begin
          found = 1'b1;
        end
        if (found != fault_r) begin
          fault_nxt = found;
          if (!found) begin
            override_nxt = 1'b0;
          end
        end
      end
      shc_pkg::OP_TIMER: begin
        if (temp_ext > shc_pkg::deg_scale(shutdown_temp_r)) begin
          power_nxt = 1'b0;
          level_nxt = shc_pkg::LVL_OFF;
          fault_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r     <= 1'b0;
      level_r     <= shc_pkg::LVL_OFF;
      target_r    <= shc_pkg::TARGET_25;
      override_r  <= 1'b0;
      fault_r     <= 1'b0;
      temp_r      <= 24'sd0;
      ppin_prev_r <= 1'b0;
      lpin_prev_r <= 1'b0;
      ppress_r    <= 32'd0;
      lpress_r    <= 32'd0;
      pulse_r     <= 16'd0;
      wrote_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        power_r     <= power_nxt;
        level_r     <= level_nxt;
        target_r    <= target_nxt;
        override_r  <= override_nxt;
        fault_r     <= fault_nxt;
        temp_r      <= temp_nxt;
        ppin_prev_r <= ppin_prev_nxt;
        lpin_prev_r <= lpin_prev_nxt;
        ppress_r    <= ppress_nxt;
        lpress_r    <= lpress_nxt;
        pulse_r     <= pulse_nxt;
        wrote_r     <= wrote_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result item is the state left by the last event
  assign out_valid          = out_valid_r;
  assign out_heat_level     = level_r;
  assign out_pulse_width    = pulse_r;
  assign out_pwm_written    = wrote_r;
  assign out_power_state    = power_r;
  assign out_heating_lamp   = power_r && (level_r != shc_pkg::LVL_OFF);
  assign out_fault_lamp     = fault_r;
  assign out_override_state = override_r;
  assign out_target_degrees = target_r;

  `SHC_ASSERT_NOW(a_off_no_level, !power_r, level_r == shc_pkg::LVL_OFF,
                  "level set while power off")
  `SHC_ASSERT_NOW(a_target_legal, 1'b1,
                  target_r == shc_pkg::TARGET_25 || target_r == shc_pkg::TARGET_30 ||
                  target_r == shc_pkg::TARGET_35, "target out of set")
  `SHC_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_r,
                   "advanced item produced no result")
  `SHC_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r && out_stall,
                  "input stalled without a blocked item")

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import shc_pkg::*;

  localparam int DEG_COUNTS     = 20480;
  localparam int SENSOR_ZERO    = 1475 * 4096;
  localparam int SENSOR_SLOPE   = 2475;
  localparam int IDLE_PCT       = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int unsigned DUTY_PCT [4] = '{0, 25, 50, 75};

  typedef struct packed {
    level_t      heat;
    logic [15:0] pulse;
    logic        written;
    logic        power;
    logic        lamp;
    logic        fault;
    logic        override_on;
    logic [5:0]  target;
  } heater_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_SAMPLE;
  logic [11:0] in_adc_code = '0;
  logic        in_power_pin = 1'b1;
  logic        in_level_pin = 1'b1;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_heat_level;
  logic [15:0] out_pulse_width;
  logic        out_pwm_written;
  logic        out_power_state;
  logic        out_heating_lamp;
  logic        out_fault_lamp;
  logic        out_override_state;
  logic [5:0]  out_target_degrees;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register mirror
  logic [6:0]  cfg_max;
  logic [6:0]  cfg_min;
  logic [6:0]  cfg_shut;
  logic [3:0]  cfg_hyst;
  logic [4:0]  cfg_margin;
  logic [15:0] cfg_lockout;
  logic [15:0] cfg_period;

  // controller state as predicted
  logic        heater_power;
  level_t      heater_level;
  logic [5:0]  heater_target;
  logic        heater_override;
  logic        heater_fault;
  int          heater_temp;
  logic        heater_ppin_prev;
  logic        heater_lpin_prev;
  logic [31:0] pwr_press_ms;
  logic [31:0] lvl_press_ms;
  logic [15:0] heater_pulse;

  heater_status_t expected_status [$];
  int unsigned error_count = 0;
  int unsigned events_sent = 0;
  int unsigned results_checked = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};
  int unsigned power_toggles = 0;
  int unsigned target_sets = 0;
  int unsigned shutdowns = 0;
  int unsigned settings_used = 1;
  int unsigned idle_cycles = 0;
  bit          steady_run = 1'b0;
  logic [31:0] clock_ms = '0;

  seat_heater_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_adc_code        (in_adc_code),
    .in_power_pin       (in_power_pin),
    .in_level_pin       (in_level_pin),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_heat_level     (out_heat_level),
    .out_pulse_width    (out_pulse_width),
    .out_pwm_written    (out_pwm_written),
    .out_power_state    (out_power_state),
    .out_heating_lamp   (out_heating_lamp),
    .out_fault_lamp     (out_fault_lamp),
    .out_override_state (out_override_state),
    .out_target_degrees (out_target_degrees),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic reset_heater_model();
    cfg_max          = MAX_TEMP_RST;
    cfg_min          = MIN_TEMP_RST;
    cfg_shut         = SHUTDOWN_TEMP_RST;
    cfg_hyst         = HYSTERESIS_RST;
    cfg_margin       = HIGH_MARGIN_RST;
    cfg_lockout      = LOCKOUT_MS_RST;
    cfg_period       = PWM_PERIOD_RST;
    heater_power     = 1'b0;
    heater_level     = LVL_OFF;
    heater_target    = TARGET_25;
    heater_override  = 1'b0;
    heater_fault     = 1'b0;
    heater_temp      = 0;
    heater_ppin_prev = 1'b0;
    heater_lpin_prev = 1'b0;
    pwr_press_ms     = '0;
    lvl_press_ms     = '0;
    heater_pulse     = '0;
  endtask

  function automatic heater_status_t apply_event(input op_t op, input logic [11:0] code,
                                                 input logic pp, input logic lp,
                                                 input logic [31:0] now);
    heater_status_t r;
    longint gap;
    logic found;
    logic written;
    written = 1'b0;
    case (op)
      OP_SAMPLE: begin
        heater_temp = SENSOR_ZERO - SENSOR_SLOPE * int'(code);
        gap = longint'(heater_target) * DEG_COUNTS - longint'(heater_temp);
        if (!heater_power || heater_override) begin
          heater_level = LVL_OFF;
        end else if (gap > (longint'(cfg_hyst) + longint'(cfg_margin)) * DEG_COUNTS) begin
          heater_level = LVL_HIGH;
        end else if (gap > longint'(cfg_hyst) * DEG_COUNTS) begin
          heater_level = LVL_MED;
        end else if (gap > 0) begin
          heater_level = LVL_LOW;
        end else begin
          heater_level = LVL_OFF;
        end
        heater_pulse = 16'((32'(cfg_period) * DUTY_PCT[heater_level]) / 100);
        written = 1'b1;
      end
      OP_BUTTON: begin
        if (!pp && heater_ppin_prev && (now - pwr_press_ms) > 32'(cfg_lockout)) begin
          heater_power = !heater_power;
          if (!heater_power) begin
            heater_level = LVL_OFF;
          end
          pwr_press_ms = now;
          power_toggles++;
        end
        heater_ppin_prev = pp;
        if (!lp && heater_lpin_prev && heater_power &&
            (now - lvl_press_ms) > 32'(cfg_lockout)) begin
          case (heater_level)
            LVL_LOW: heater_target = TARGET_30;
            LVL_MED: heater_target = TARGET_35;
            default: heater_target = TARGET_25;
          endcase
          lvl_press_ms = now;
          target_sets++;
        end
        heater_lpin_prev = lp;
      end
      OP_SAFETY: begin
        found = 1'b0;
        if (longint'(heater_temp) > longint'(cfg_max) * DEG_COUNTS) begin
          found = 1'b1;
          heater_override = 1'b1;
        end else if (longint'(heater_temp) < longint'(cfg_min) * DEG_COUNTS &&
                     heater_level != LVL_OFF) begin
          found = 1'b1;
        end
        if (found != heater_fault) begin
          heater_fault = found;
          if (!found) begin
            heater_override = 1'b0;
          end
        end
      end
      OP_TIMER: begin
        if (longint'(heater_temp) > longint'(cfg_shut) * DEG_COUNTS) begin
          heater_power = 1'b0;
          heater_level = LVL_OFF;
          heater_fault = 1'b1;
          shutdowns++;
        end
      end
    endcase
    r.heat        = heater_level;
    r.pulse       = heater_pulse;
    r.written     = written;
    r.power       = heater_power;
    r.lamp        = heater_power && heater_level != LVL_OFF;
    r.fault       = heater_fault;
    r.override_on = heater_override;
    r.target      = heater_target;
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    heater_status_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(apply_event(op_t'(in_op), in_adc_code, in_power_pin,
                                              in_level_pin, in_now_ms));
        op_count[in_op]++;
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result with no event pending, expected none, got level %0d target %0d",
                   $time, out_heat_level, out_target_degrees);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("heat_level", want.heat, out_heat_level);
          check_field("pulse_width", want.pulse, out_pulse_width);
          check_field("pwm_written", want.written, out_pwm_written);
          check_field("power_state", want.power, out_power_state);
          check_field("heating_lamp", want.lamp, out_heating_lamp);
          check_field("fault_lamp", want.fault, out_fault_lamp);
          check_field("override_state", want.override_on, out_override_state);
          check_field("target_degrees", want.target, out_target_degrees);
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send_event(input op_t op, input logic [11:0] code, input logic pp,
                            input logic lp, input logic [31:0] now);
    if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_adc_code  <= code;
    in_power_pin <= pp;
    in_level_pin <= lp;
    in_now_ms    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAX_TEMP:      cfg_max = value[6:0];
      REG_MIN_TEMP:      cfg_min = value[6:0];
      REG_SHUTDOWN_TEMP: cfg_shut = value[6:0];
      REG_HYSTERESIS:    cfg_hyst = value[3:0];
      REG_HIGH_MARGIN:   cfg_margin = value[4:0];
      REG_LOCKOUT_MS:    cfg_lockout = value[15:0];
      REG_PWM_PERIOD:    cfg_period = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unused upper bits get random junk when asked
  function automatic logic [31:0] pad_value(input logic [31:0] v, input int w, input bit junk);
    return junk ? (($urandom << w) | v) : v;
  endfunction

  task automatic program_settings(input logic [6:0] t_max, t_min, t_shut,
                                  input logic [3:0] hyst, input logic [4:0] margin,
                                  input logic [15:0] lockout, period, input bit junk);
    wait_until_drained();
    write_register(REG_MAX_TEMP, pad_value(32'(t_max), 7, junk));
    write_register(REG_MIN_TEMP, pad_value(32'(t_min), 7, junk));
    write_register(REG_SHUTDOWN_TEMP, pad_value(32'(t_shut), 7, junk));
    write_register(REG_HYSTERESIS, pad_value(32'(hyst), 4, junk));
    write_register(REG_HIGH_MARGIN, pad_value(32'(margin), 5, junk));
    write_register(REG_LOCKOUT_MS, pad_value(32'(lockout), 16, junk));
    write_register(REG_PWM_PERIOD, pad_value(32'(period), 16, junk));
    settings_used++;
  endtask

  function automatic logic [11:0] pick_adc_code();
    int unsigned r;
    int deg;
    r = $urandom_range(99);
    if (r < 15) begin
      // codes right around a whole degree
      deg = $urandom_range(127);
      return 12'((SENSOR_ZERO - DEG_COUNTS * deg) / SENSOR_SLOPE + $urandom_range(1));
    end
    if (r < 30) begin
      return 12'($urandom_range(4095));
    end
    return 12'($urandom_range(2420, 1950));
  endfunction

  task automatic advance_clock_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) begin
      clock_ms += $urandom_range(cfg_lockout);
    end else if (r < 40) begin
      clock_ms += cfg_lockout;
    end else if (r < 50) begin
      clock_ms += 32'(cfg_lockout) + 1;
    end else if (r < 90) begin
      clock_ms += 32'(cfg_lockout) + $urandom_range(2000, 1);
    end else if (r < 97) begin
      clock_ms += $urandom;
    end else begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(300);
    end
  endtask

  task automatic send_random_event();
    int unsigned pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 40) begin
      op = OP_SAMPLE;
    end else if (pick < 75) begin
      op = OP_BUTTON;
    end else if (pick < 90) begin
      op = OP_SAFETY;
    end else begin
      op = OP_TIMER;
    end
    advance_clock_ms();
    send_event(op, pick_adc_code(), $urandom_range(99) >= 35, $urandom_range(99) >= 35,
               clock_ms);
  endtask

  task automatic test_directed_events();
    send_event(OP_SAMPLE, 12'd0, 1'b1, 1'b1, 32'd0);
    send_event(OP_SAMPLE, 12'hFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // pins start low in the model, so no press yet
    send_event(OP_BUTTON, 12'hFFF, 1'b0, 1'b0, 32'd1000);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'd1100);
    send_event(OP_BUTTON, 12'd0, 1'b0, 1'b1, 32'd1300);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'd1350);
    // exactly the lockout after the last press
    send_event(OP_BUTTON, 12'd0, 1'b0, 1'b1, 32'd1500);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'd1550);
    send_event(OP_SAMPLE, 12'd2250, 1'b1, 1'b1, 32'd1560);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b0, 32'd1600);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'd1650);
    send_event(OP_SAMPLE, 12'd2226, 1'b1, 1'b1, 32'd1700);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b0, 32'd1900);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'd1950);
    send_event(OP_SAMPLE, 12'd4095, 1'b1, 1'b1, 32'd2000);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b0, 32'd2200);
    send_event(OP_SAFETY, 12'd0, 1'b1, 1'b1, 32'd2300);
    send_event(OP_SAMPLE, 12'd1900, 1'b1, 1'b1, 32'd2400);
    send_event(OP_SAFETY, 12'hFFF, 1'b0, 1'b0, 32'd2500);
    send_event(OP_TIMER, 12'd0, 1'b1, 1'b1, 32'd2600);
    send_event(OP_SAMPLE, 12'd2250, 1'b1, 1'b1, 32'd2700);
    send_event(OP_SAFETY, 12'd0, 1'b1, 1'b1, 32'd2800);
    // press time near the top, next press after the counter wraps
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'hFFFF_FE00);
    send_event(OP_BUTTON, 12'd0, 1'b0, 1'b1, 32'hFFFF_FF00);
    send_event(OP_BUTTON, 12'd0, 1'b1, 1'b1, 32'hFFFF_FF80);
    send_event(OP_BUTTON, 12'd0, 1'b0, 1'b1, 32'h0000_0010);
  endtask

  task automatic test_reset_settings_traffic();
    repeat (175) send_random_event();
    wait_until_drained();
    repeat (175) send_random_event();
  endtask

  task automatic test_steady_stream();
    wait_until_drained();
    steady_run = 1'b1;
    repeat (250) send_random_event();
    wait_until_drained();
    steady_run = 1'b0;
  endtask

  task automatic test_register_extremes();
    program_settings(7'd0, 7'd0, 7'd0, 4'd0, 5'd0, 16'd0, 16'd0, 1'b0);
    repeat (250) send_random_event();
    program_settings(7'd127, 7'd127, 7'd127, 4'd15, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
    repeat (250) send_random_event();
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      program_settings(7'($urandom_range(70, 30)), 7'($urandom_range(30)),
                       7'($urandom_range(80, 35)), 4'($urandom_range(15)),
                       5'($urandom_range(31)), 16'($urandom_range(1000)),
                       16'($urandom), 1'b1);
      repeat (285) send_random_event();
    end
  endtask

  initial begin
    reset_heater_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_reset_settings_traffic();
    test_steady_stream();
    test_register_extremes();
    test_random_settings();
    wait_until_drained();
    $display("run covered %0d events: %0d samples, %0d button polls, %0d safety checks,",
             events_sent, op_count[OP_SAMPLE], op_count[OP_BUTTON], op_count[OP_SAFETY]);
    $display("%0d timer events, %0d results compared under %0d register settings",
             op_count[OP_TIMER], results_checked, settings_used);
    $display("seen: %0d power toggles, %0d target changes, %0d timer shutdowns",
             power_toggles, target_sets, shutdowns);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- seat_heater_controller.f -----
+incdir+design
design/shc_pkg.sv
design/seat_heater_controller.sv
tb/tb_top.sv
